/* hw/rtl/opsd_pkg.sv */
// Shared types and constants for the opack stream decoder.
package opsd_pkg;

   typedef struct packed {
      logic [3:0] cnt;
      logic       val;
      logic       term;
      logic       dict;
   } entry_type;

   localparam logic [3:0] CLS_TERM      = 4'd0;
   localparam logic [3:0] CLS_INVALID   = 4'd1;
   localparam logic [3:0] CLS_BOOL      = 4'd2;
   localparam logic [3:0] CLS_FIELD     = 4'd3;
   localparam logic [3:0] CLS_SMALLINT  = 4'd4;
   localparam logic [3:0] CLS_SHORTLEN  = 4'd5;
   localparam logic [3:0] CLS_LONGLEN   = 4'd6;
   localparam logic [3:0] CLS_CONTAINER = 4'd7;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
      logic [3:0] hclass;
      logic       is_str;
   } item_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic [4:0]  nest_depth;
      logic        is_key;
      logic [4:0]  closes;
      logic [2:0]  err_code;
      logic        msg_end;
   } result_type;

   localparam logic [3:0] KIND_NONE   = 4'd0;
   localparam logic [3:0] KIND_BOOL   = 4'd1;
   localparam logic [3:0] KIND_UINT   = 4'd2;
   localparam logic [3:0] KIND_REAL32 = 4'd3;
   localparam logic [3:0] KIND_REAL64 = 4'd4;
   localparam logic [3:0] KIND_DATE   = 4'd5;
   localparam logic [3:0] KIND_STR    = 4'd6;
   localparam logic [3:0] KIND_DATA   = 4'd7;
   localparam logic [3:0] KIND_PAYLD  = 4'd8;
   localparam logic [3:0] KIND_DICT   = 4'd9;
   localparam logic [3:0] KIND_ARRAY  = 4'd10;
   localparam logic [3:0] KIND_CLOSE  = 4'd11;
   localparam logic [3:0] KIND_ERROR  = 4'd12;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_INVALID   = 3'd1;
   localparam logic [2:0] ERR_KEY       = 3'd2;
   localparam logic [2:0] ERR_TERM      = 3'd3;
   localparam logic [2:0] ERR_TRUNC     = 3'd4;
   localparam logic [2:0] ERR_DEEP      = 3'd5;

   localparam logic [7:0] T_TRUE  = 8'h01;
   localparam logic [7:0] T_FALSE = 8'h02;
   localparam logic [7:0] T_TERM  = 8'h03;
   localparam logic [7:0] T_DATE  = 8'h06;
   localparam logic [7:0] T_INT0  = 8'h08;
   localparam logic [7:0] T_U8    = 8'h30;
   localparam logic [7:0] T_U32   = 8'h32;
   localparam logic [7:0] T_U64   = 8'h33;
   localparam logic [7:0] T_F32   = 8'h35;
   localparam logic [7:0] T_F64   = 8'h36;
   localparam logic [7:0] T_STR0  = 8'h40;
   localparam logic [7:0] T_STRL  = 8'h61;
   localparam logic [7:0] T_STRX  = 8'h64;
   localparam logic [7:0] T_DATA0 = 8'h70;
   localparam logic [7:0] T_DATAL = 8'h91;
   localparam logic [7:0] T_DATAX = 8'h94;
   localparam logic [7:0] T_ARR0  = 8'hD0;
   localparam logic [7:0] T_DICT0 = 8'hE0;
   localparam logic [7:0] T_DICTX = 8'hEF;

   function automatic logic [3:0] classify(input logic [7:0] t);
      logic [3:0] c;
      c = CLS_INVALID;
      if (t == T_TERM) c = CLS_TERM;
      else if (t == T_TRUE || t == T_FALSE) c = CLS_BOOL;
      else if (t == T_DATE || t == T_U8 || t == T_U32 || t == T_U64 ||
               t == T_F32 || t == T_F64) c = CLS_FIELD;
      else if (t >= T_INT0 && t < T_U8) c = CLS_SMALLINT;
      else if ((t >= T_STR0 && t < T_STRL) || (t >= T_DATA0 && t < T_DATAL))
         c = CLS_SHORTLEN;
      else if ((t >= T_STRL && t <= T_STRX) || (t >= T_DATAL && t <= T_DATAX))
         c = CLS_LONGLEN;
      else if (t >= T_ARR0 && t <= T_DICTX) c = CLS_CONTAINER;
      return c;
   endfunction

endpackage

/* hw/rtl/opsd_req_if.sv */
// Channel interfaces for message bytes and token events.
interface opsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;
   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface opsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [63:0] value;
   logic [4:0]  nest_depth;
   logic        is_key;
   logic [4:0]  closes;
   logic [2:0]  err_code;
   logic        msg_end;
   modport source (output valid, output kind, output value, output nest_depth,
                   output is_key, output closes, output err_code, output msg_end,
                   input ready);
   modport sink (input valid, input kind, input value, input nest_depth,
                 input is_key, input closes, input err_code, input msg_end,
                 output ready);
endinterface

/* hw/rtl/opsd_front.sv */
// Front end: accepts bytes, classifies header codes, two-entry queue.
module opsd_front
   import opsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output logic           q_valid,
   output item_type       q_item,
   input  logic           q_take
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   item_type    new_item;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.byte_in   = in_byte;
      new_item.last_byte = in_last;
      new_item.hclass    = classify(in_byte);
      new_item.is_str    = (in_byte >= T_STR0) && (in_byte <= T_STRX);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_take;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hw/rtl/opsd_back.sv */
// Back end: decode state, nesting stack, close cascade and result register.
module opsd_back
   import opsd_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  item_type       q_item,
   output logic           q_take,
   output logic           out_valid,
   input  logic           out_ready,
   output result_type     out_data
);

   localparam int LW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_FIELD   = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   entry_type   mem [STACK_DEPTH];
   entry_type   rd_ff;
   logic        we;
   logic [AW-1:0] wa;
   logic [AW-1:0] ra;
   entry_type   wd;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [LW-1:0] level_ff, level_in;
   logic        discard_ff, discard_in;
   entry_type   top_ff, top_in;
   logic [3:0]  fleft_ff, fleft_in;
   logic [2:0]  fidx_ff, fidx_in;
   logic [3:0]  fkind_ff, fkind_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] pleft_ff, pleft_in;

   logic [3:0]  p_kind_ff, p_kind_in;
   logic [63:0] p_value_ff, p_value_in;
   logic [4:0]  p_depth_ff, p_depth_in;
   logic [4:0]  p_lvl0_ff, p_lvl0_in;
   logic        p_key_ff, p_key_in;
   logic [4:0]  p_closes_ff, p_closes_in;
   logic        p_last_ff, p_last_in;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   logic        can_emit, key_pos;
   logic [7:0]  t;
   logic [63:0] acc_new;
   logic [LW-1:0] lvl_dec;
   entry_type   e;
   logic [3:0]  cnt_dec;

   logic        fin, f_ended, f_last, f_key, err4;
   logic [3:0]  f_kind;
   logic [63:0] f_value;
   logic [4:0]  f_depth, f_lvl0, f_closes;
   logic [2:0]  f_err;
   logic        stp, pop, dn;

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign can_emit  = !out_valid_ff || out_ready;
   assign t         = q_item.byte_in;
   assign key_pos   = (level_ff != '0) && top_ff.dict && !top_ff.val;
   assign acc_new   = acc_ff | ({56'b0, t} << {fidx_ff, 3'b000});
   assign lvl_dec   = level_ff - LW'(1);
   assign ra        = AW'(level_ff - LW'(2));

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      level_in    = level_ff;
      discard_in  = discard_ff;
      top_in      = top_ff;
      fleft_in    = fleft_ff;
      fidx_in     = fidx_ff;
      fkind_in    = fkind_ff;
      acc_in      = acc_ff;
      pleft_in    = pleft_ff;
      p_kind_in   = p_kind_ff;
      p_value_in  = p_value_ff;
      p_depth_in  = p_depth_ff;
      p_lvl0_in   = p_lvl0_ff;
      p_key_in    = p_key_ff;
      p_closes_in = p_closes_ff;
      p_last_in   = p_last_ff;
      out_in      = out_ff;
      out_valid_in = out_valid_ff && !out_ready;
      q_take  = 1'b0;
      we      = 1'b0;
      wa      = AW'(lvl_dec);
      wd      = top_ff;
      fin     = 1'b0;
      f_kind  = KIND_NONE;
      f_value = '0;
      f_depth = 5'(level_ff);
      f_lvl0  = 5'(level_ff);
      f_key   = key_pos;
      f_closes = '0;
      f_err   = ERR_NONE;
      f_ended = 1'b0;
      f_last  = q_item.last_byte;
      stp     = 1'b0;
      pop     = 1'b0;
      dn      = 1'b0;
      e       = top_ff;
      cnt_dec = top_ff.cnt - 4'd1;
      err4    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && can_emit) begin
               q_take = 1'b1;
               if (discard_ff) begin
                  out_in       = '0;
                  out_valid_in = 1'b1;
                  if (q_item.last_byte) begin
                     phase_in   = PH_HEADER;
                     level_in   = '0;
                     discard_in = 1'b0;
                     fleft_in   = '0;
                     acc_in     = '0;
                     pleft_in   = '0;
                  end
               end else begin
                  case (phase_ff)
                     PH_HEADER: begin
                        if (q_item.hclass == CLS_TERM) begin
                           if (level_ff == '0) begin
                              f_key = 1'b0;
                           end else if ((top_ff.dict && top_ff.val) ||
                                        (!top_ff.dict && !top_ff.term)) begin
                              f_err = ERR_TERM;
                           end else begin
                              f_kind   = KIND_CLOSE;
                              f_depth  = 5'(lvl_dec);
                              f_key    = 1'b0;
                              f_closes = 5'd1;
                              level_in = lvl_dec;
                              pop      = 1'b1;
                              if (lvl_dec == '0) f_ended = 1'b1;
                           end
                        end else if (q_item.hclass == CLS_INVALID) begin
                           f_err = ERR_INVALID;
                        end else if (key_pos && !q_item.is_str) begin
                           f_err = ERR_KEY;
                        end else begin
                           case (q_item.hclass)
                              CLS_BOOL: begin
                                 f_kind  = KIND_BOOL;
                                 f_value = {63'b0, t == T_TRUE};
                                 dn      = 1'b1;
                              end
                              CLS_FIELD: begin
                                 phase_in = PH_FIELD;
                                 fidx_in  = '0;
                                 acc_in   = '0;
                                 fleft_in = (t == T_U8) ? 4'd1 :
                                            (t == T_U32 || t == T_F32) ? 4'd4 : 4'd8;
                                 fkind_in = (t == T_DATE) ? KIND_DATE :
                                            (t == T_F32) ? KIND_REAL32 :
                                            (t == T_F64) ? KIND_REAL64 : KIND_UINT;
                              end
                              CLS_SMALLINT: begin
                                 f_kind  = KIND_UINT;
                                 f_value = {56'b0, t - T_INT0};
                                 dn      = 1'b1;
                              end
                              CLS_SHORTLEN: begin
                                 f_kind  = (t < T_DATA0) ? KIND_STR : KIND_DATA;
                                 f_value = {56'b0, t - ((t < T_DATA0) ? T_STR0 : T_DATA0)};
                                 if (f_value == '0) begin
                                    dn = 1'b1;
                                 end else begin
                                    pleft_in = f_value;
                                    phase_in = PH_PAYLOAD;
                                 end
                              end
                              CLS_LONGLEN: begin
                                 phase_in = PH_LENGTH;
                                 fidx_in  = '0;
                                 acc_in   = '0;
                                 fleft_in = 4'd1 << (t[1:0] - 2'd1);
                                 fkind_in = (t < T_DATA0) ? KIND_STR : KIND_DATA;
                              end
                              default: begin
                                 if (t[3:0] == 4'd0) begin
                                    f_kind   = t[5] ? KIND_DICT : KIND_ARRAY;
                                    f_closes = 5'd1;
                                    if (level_ff == '0) f_ended = 1'b1;
                                    else stp = 1'b1;
                                 end else if (level_ff >= LW'(STACK_DEPTH)) begin
                                    f_err = ERR_DEEP;
                                 end else begin
                                    f_kind      = t[5] ? KIND_DICT : KIND_ARRAY;
                                    f_value     = {60'b0, t[3:0]};
                                    top_in.dict = t[5];
                                    top_in.term = (t[3:0] == 4'hF);
                                    top_in.val  = 1'b0;
                                    top_in.cnt  = (t[3:0] == 4'hF) ? 4'd0 : t[3:0];
                                    level_in    = level_ff + LW'(1);
                                    we          = (level_ff != '0);
                                 end
                              end
                           endcase
                        end
                     end
                     PH_FIELD, PH_LENGTH: begin
                        acc_in   = acc_new;
                        fidx_in  = fidx_ff + 3'd1;
                        fleft_in = fleft_ff - 4'd1;
                        if (fleft_ff == 4'd1) begin
                           f_value = acc_new;
                           f_kind  = fkind_ff;
                           if (phase_ff == PH_FIELD || acc_new == '0) begin
                              phase_in = PH_HEADER;
                              dn       = 1'b1;
                           end else begin
                              pleft_in = acc_new;
                              phase_in = PH_PAYLOAD;
                           end
                        end
                     end
                     default: begin
                        f_kind   = KIND_PAYLD;
                        f_value  = {56'b0, t};
                        pleft_in = pleft_ff - 64'd1;
                        if (pleft_ff == 64'd1) begin
                           phase_in = PH_HEADER;
                           dn       = 1'b1;
                        end
                     end
                  endcase
                  if (dn && level_ff != '0) stp = 1'b1;
                  if (stp || (pop && !f_ended)) begin
                     state_in    = stp ? ST_STEP : ST_FILL;
                     p_kind_in   = f_kind;
                     p_value_in  = f_value;
                     p_depth_in  = f_depth;
                     p_lvl0_in   = f_lvl0;
                     p_key_in    = f_key;
                     p_closes_in = f_closes;
                     p_last_in   = q_item.last_byte;
                  end else begin
                     fin = 1'b1;
                  end
               end
            end
         end
         ST_FILL: begin
            top_in   = rd_ff;
            state_in = ST_STEP;
         end
         default: begin
            if (can_emit) begin
               f_kind   = p_kind_ff;
               f_value  = p_value_ff;
               f_depth  = p_depth_ff;
               f_lvl0   = p_lvl0_ff;
               f_key    = p_key_ff;
               f_closes = p_closes_ff;
               f_last   = p_last_ff;
               state_in = ST_IDLE;
               fin      = 1'b1;
               if (top_ff.dict && !top_ff.val) begin
                  top_in.val = 1'b1;
               end else begin
                  e.val = 1'b0;
                  if (e.term) begin
                     top_in = e;
                  end else if (cnt_dec != 4'd0) begin
                     top_in     = e;
                     top_in.cnt = cnt_dec;
                  end else begin
                     level_in    = lvl_dec;
                     f_closes    = p_closes_ff + 5'd1;
                     p_closes_in = f_closes;
                     if (lvl_dec == '0) begin
                        f_ended = 1'b1;
                     end else begin
                        fin      = 1'b0;
                        state_in = ST_FILL;
                     end
                  end
               end
            end
         end
      endcase

      if (fin) begin
         err4 = (f_err == ERR_NONE) && !f_ended && f_last &&
                (phase_in != PH_HEADER || level_in != '0);
         if (err4) f_err = ERR_TRUNC;
         out_in.kind       = f_kind;
         out_in.value      = f_value;
         out_in.nest_depth = f_depth;
         out_in.is_key     = f_key;
         out_in.closes     = f_closes;
         out_in.err_code   = f_err;
         out_in.msg_end    = f_ended || (f_err != ERR_NONE) || f_last;
         if (f_err != ERR_NONE) begin
            out_in.kind       = KIND_ERROR;
            out_in.value      = '0;
            out_in.nest_depth = f_lvl0;
            out_in.is_key     = 1'b0;
            out_in.closes     = '0;
            discard_in        = 1'b1;
         end else if (f_kind == KIND_NONE) begin
            out_in.nest_depth = '0;
            out_in.is_key     = 1'b0;
         end
         if (f_ended) discard_in = 1'b1;
         out_valid_in = 1'b1;
         if (f_last) begin
            phase_in   = PH_HEADER;
            level_in   = '0;
            discard_in = 1'b0;
            fleft_in   = '0;
            acc_in     = '0;
            pleft_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HEADER;
         level_ff     <= '0;
         discard_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         discard_ff   <= discard_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      fleft_ff    <= fleft_in;
      fidx_ff     <= fidx_in;
      fkind_ff    <= fkind_in;
      acc_ff      <= acc_in;
      pleft_ff    <= pleft_in;
      p_kind_ff   <= p_kind_in;
      p_value_ff  <= p_value_in;
      p_depth_ff  <= p_depth_in;
      p_lvl0_ff   <= p_lvl0_in;
      p_key_ff    <= p_key_in;
      p_closes_ff <= p_closes_in;
      p_last_ff   <= p_last_in;
      out_ff      <= out_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

endmodule

/* hw/rtl/opack_stream_decoder.sv */
// Top level of the opack stream decoder: front queue plus decode back end.
//
// Takes one message byte per transaction and returns one token event per byte. A byte is normally
// decoded in the idle state alone. A byte that completes an element inside a container also
// passes through ST_STEP to update that container's stack entry. Each container that then closes
// reloads the next stack entry from the nesting memory (STACK_DEPTH entries) in ST_FILL and
// updates it in ST_STEP, except the close that ends the top-level container, which needs neither
// step. A terminator that closes a nested container likewise passes through a reload and an
// update step. The back end stalls while a finished event waits on rsp_bus; a two-entry queue
// in front keeps taking bytes, until it is full, during stalls and the extra steps.
module opack_stream_decoder
   import opsd_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   opsd_req_if.sink    req_bus,
   opsd_rsp_if.source  rsp_bus
);

   logic       q_valid;
   logic       q_take;
   item_type   q_item;
   result_type res;

   opsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_byte  (req_bus.byte_in),
      .in_last  (req_bus.last_byte),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take)
   );

   opsd_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_take    (q_take),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (res)
   );

   assign rsp_bus.kind       = res.kind;
   assign rsp_bus.value      = res.value;
   assign rsp_bus.nest_depth = res.nest_depth;
   assign rsp_bus.is_key     = res.is_key;
   assign rsp_bus.closes     = res.closes;
   assign rsp_bus.err_code   = res.err_code;
   assign rsp_bus.msg_end    = res.msg_end;

endmodule

/* hw/rtl/opsd_checker.sv */
// Port-level checks for the opack stream decoder, bound to the top level.
module opsd_checker
   import opsd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  kind,
   input logic [63:0] value,
   input logic [4:0]  closes,
   input logic [2:0]  err_code,
   input logic        is_key,
   input logic        msg_end
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(value) && $stable(kind))
      else $error("event changed while stalled");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_ERROR |-> msg_end && err_code != ERR_NONE &&
      closes == 5'd0 && !is_key && value == 64'd0)
      else $error("malformed error event");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_code != ERR_NONE |-> kind == KIND_ERROR)
      else $error("error code without error kind");

   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind == KIND_CLOSE |-> closes != 5'd0 && !is_key)
      else $error("close event without a close count");

endmodule

bind opack_stream_decoder opsd_checker u_opsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .kind      (rsp_bus.kind),
   .value     (rsp_bus.value),
   .closes    (rsp_bus.closes),
   .err_code  (rsp_bus.err_code),
   .is_key    (rsp_bus.is_key),
   .msg_end   (rsp_bus.msg_end)
);
